FILE: design/multi_tap_keypad_decoder_macros.svh
// Assertion macros shared by the checker.
`ifndef MULTI_TAP_KEYPAD_DECODER_MACROS_SVH
`define MULTI_TAP_KEYPAD_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define MTKD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define MTKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mtkd_pkg.sv
`default_nettype none

package mtkd_pkg;

  localparam int DEF_TIMEOUT_BITS = 8;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;
  localparam int RESQ_DEPTH       = 4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic       REG_TIMEOUT   = 1'b0;

  localparam logic OP_KEY    = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LED  = 1'b1;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_CR = 8'h0d;

  localparam logic [3:0] NUM_KEYS  = 4'd12;
  localparam logic [3:0] KEY_MODE  = 4'd9;
  localparam logic [3:0] KEY_ENTER = 4'd11;

  localparam logic [1:0] MODE_LOWER  = 2'd0;
  localparam logic [1:0] MODE_UPPER  = 2'd1;
  localparam logic [1:0] MODE_DIGIT  = 2'd2;
  localparam logic [1:0] MODE_SYMBOL = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       led_on;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Raw pad key to logical key.
  function automatic logic [3:0] key_perm(input logic [3:0] raw);
    logic [3:0] k;
    case (raw)
      4'd0:    k = 4'd2;
      4'd1:    k = 4'd5;
      4'd2:    k = 4'd8;
      4'd3:    k = 4'd11;
      4'd4:    k = 4'd1;
      4'd5:    k = 4'd4;
      4'd6:    k = 4'd7;
      4'd7:    k = 4'd10;
      4'd8:    k = 4'd0;
      4'd9:    k = 4'd3;
      4'd10:   k = 4'd6;
      4'd11:   k = 4'd9;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

  // Layout string of a key, first character in the top byte, zero padded.
  function automatic logic [39:0] char_row(input logic [1:0] mode, input logic [3:0] k);
    logic [39:0] row;
    row = '0;
    case (mode)
      MODE_LOWER, MODE_UPPER: begin
        case (k)
          4'd0:    row = " ,.!?";
          4'd1:    row = (mode == MODE_LOWER) ? {"abc", 16'h0} : {"ABC", 16'h0};
          4'd2:    row = (mode == MODE_LOWER) ? {"def", 16'h0} : {"DEF", 16'h0};
          4'd3:    row = (mode == MODE_LOWER) ? {"ghi", 16'h0} : {"GHI", 16'h0};
          4'd4:    row = (mode == MODE_LOWER) ? {"jkl", 16'h0} : {"JKL", 16'h0};
          4'd5:    row = (mode == MODE_LOWER) ? {"mno", 16'h0} : {"MNO", 16'h0};
          4'd6:    row = (mode == MODE_LOWER) ? {"pqr", 16'h0} : {"PQR", 16'h0};
          4'd7:    row = (mode == MODE_LOWER) ? {"stuv", 8'h0} : {"STUV", 8'h0};
          4'd8:    row = (mode == MODE_LOWER) ? {"wxyz", 8'h0} : {"WXYZ", 8'h0};
          4'd9:    row = {8'h01, 32'h0};
          4'd10:   row = {CH_BS, 32'h0};
          4'd11:   row = {CH_CR, 32'h0};
          default: row = '0;
        endcase
      end
      MODE_DIGIT: begin
        case (k)
          4'd0:    row = {"1(", 24'h0};
          4'd1:    row = {"2)", 24'h0};
          4'd2:    row = {"3{", 24'h0};
          4'd3:    row = {"4}", 24'h0};
          4'd4:    row = {"5+", 24'h0};
          4'd5:    row = {"6-", 24'h0};
          4'd6:    row = {"7/", 24'h0};
          4'd7:    row = {"8_", 24'h0};
          4'd8:    row = {"9%", 24'h0};
          4'd9:    row = {8'h01, 32'h0};
          4'd10:   row = {"0", 32'h0};
          4'd11:   row = {CH_CR, 32'h0};
          default: row = '0;
        endcase
      end
      default: begin
        case (k)
          4'd1:    row = {8'hb5, 32'h0};
          4'd3:    row = {8'hb4, 32'h0};
          4'd5:    row = {8'hb7, 32'h0};
          4'd6:    row = {8'h09, 32'h0};
          4'd7:    row = {8'hb6, 32'h0};
          4'd9:    row = {8'h01, 32'h0};
          4'd10:   row = {CH_BS, 32'h0};
          4'd11:   row = {CH_CR, 32'h0};
          default: row = {8'h3f, 32'h0};
        endcase
      end
    endcase
    return row;
  endfunction

  function automatic logic [2:0] str_len(input logic [1:0] mode, input logic [3:0] k);
    logic [2:0] n;
    n = 3'd1;
    if (k > 4'd8 || mode == MODE_SYMBOL) begin
      n = 3'd1;
    end else if (mode == MODE_DIGIT) begin
      n = 3'd2;
    end else begin
      case (k)
        4'd0:       n = 3'd5;
        4'd7, 4'd8: n = 3'd4;
        default:    n = 3'd3;
      endcase
    end
    return n;
  endfunction

  function automatic logic [7:0] char_at(input logic [1:0] mode, input logic [3:0] k,
                                         input logic [2:0] pos);
    logic [39:0] row;
    logic [7:0]  c;
    row = char_row(mode, k);
    case (pos)
      3'd0:    c = row[39:32];
      3'd1:    c = row[31:24];
      3'd2:    c = row[23:16];
      3'd3:    c = row[15:8];
      3'd4:    c = row[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Mode LED level at blink phase p (phase after the step).
  function automatic logic led_level(input logic [1:0] mode, input logic [2:0] p);
    logic on;
    case (mode)
      MODE_UPPER:  on = (p == 3'd0) || (p == 3'd1);
      MODE_DIGIT:  on = (p == 3'd0) || (p == 3'd3);
      MODE_SYMBOL: on = (p == 3'd0) || (p == 3'd2) || (p == 3'd4);
      default:     on = 1'b0;
    endcase
    return on;
  endfunction

endpackage

`default_nettype wire

FILE: design/multi_tap_keypad_decoder.sv
// Multi-tap keypad decoder.
// Input channel (in_valid/in_ready): one item per handshake, either a key
//   press (in_op = 0, in_key_index = raw pad key) or a timer tick (in_op = 1).
// Result channel (out_valid/out_ready): character items (out_kind = 0) and
//   LED items (out_kind = 1); out_last marks the final result of an item.
//   A repeated key press gives two results: backspace, then the new char.
// Config: APB-style write of repeat_timeout_ticks at byte address 0;
//   pready is tied high, reads return the register.
// Path: an accepted item sits in the input register, is decoded there and
//   pushed into a 4-entry result queue once the queue has room, and its
//   results leave through the out_ ports from the queue head.
// Throughput: one item per cycle for single-result items and one result per
//   cycle overall while out_ready stays high; the result queue drain (one
//   result per cycle) sets that figure.
// Stall: when the receiver holds out_ready low the queue fills; an item in
//   the input register waits until the queue has room for two results, and
//   in_ready stays low while it waits.
// Reset (rst_n, synchronous): mode, position, previous key, timeout and
//   blink phase clear, the queue empties, the timeout register becomes 10.
`default_nettype none

module multi_tap_keypad_decoder
  import mtkd_pkg::*;
#(
  parameter int TIMEOUT_BITS = DEF_TIMEOUT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [3:0]            in_key_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [7:0]                 out_char_code,
  output logic                       out_led_on,
  output logic                       out_last,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // input register
  logic       inv_r;
  logic       op_r;
  logic [3:0] key_r;

  logic [7:0] tmo_cfg_r;

  res_pair_t  res;
  res_t       head;
  logic       room;
  logic       fire;

  // decode fires once the queue can take the worst case of two results
  assign fire     = inv_r && room;
  assign in_ready = !inv_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      key_r <= in_key_index;
    end
  end

  // config register, paddr[2] picks the word
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_cfg_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      tmo_cfg_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = CFG_DATA_W'(tmo_cfg_r);
    end
  end

  mtkd_core #(
    .TIMEOUT_BITS(TIMEOUT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (fire),
    .op      (op_r),
    .key_raw (key_r),
    .tmo_cfg (tmo_cfg_r),
    .res     (res)
  );

  mtkd_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res),
    .room       (room),
    .head_valid (out_valid),
    .pop        (out_ready),
    .head       (head)
  );

  assign out_kind      = head.kind;
  assign out_char_code = head.char_code;
  assign out_led_on    = head.led_on;
  assign out_last      = head.last;

endmodule

`default_nettype wire

FILE: design/mtkd_core.sv
`default_nettype none

module mtkd_core
  import mtkd_pkg::*;
#(
  parameter int TIMEOUT_BITS = DEF_TIMEOUT_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       commit,
  input  wire logic       op,
  input  wire logic [3:0] key_raw,
  input  wire logic [7:0] tmo_cfg,
  output res_pair_t       res
);

  localparam int LW = (TIMEOUT_BITS > 8) ? TIMEOUT_BITS : 8;
  localparam logic [LW-1:0] TMO_MAX = LW'((64'd1 << TIMEOUT_BITS) - 64'd1);

  logic [1:0]              mode_r, mode_nxt;
  logic [2:0]              pos_r, pos_nxt;
  logic [3:0]              prev_r, prev_nxt;
  logic [TIMEOUT_BITS-1:0] tmo_r, tmo_nxt;
  logic [2:0]              phase_r, phase_nxt;

  logic [LW-1:0]           cfg_ext;
  logic [TIMEOUT_BITS-1:0] tmo_load;
  logic [3:0]              k;
  logic [3:0]              np;
  logic [2:0]              phase_inc;
  logic                    is_repeat;

  assign cfg_ext   = LW'(tmo_cfg);
  assign tmo_load  = TIMEOUT_BITS'((cfg_ext > TMO_MAX) ? TMO_MAX : cfg_ext);
  assign k         = key_perm(key_raw);
  assign phase_inc = phase_r + 3'd1;
  assign is_repeat = (k == prev_r) && (tmo_r != '0) && (mode_r != MODE_SYMBOL);

  always_comb begin
    np = {1'b0, pos_r} + 4'd1;
    if (np >= {1'b0, str_len(mode_r, k)}) begin
      np = 4'd0;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    tmo_nxt   = tmo_r;
    phase_nxt = phase_r;
    res       = '0;
    if (op == OP_TICK) begin
      if (tmo_r != '0) begin
        tmo_nxt = tmo_r - TIMEOUT_BITS'(1);
      end
      phase_nxt        = phase_inc;
      res.cnt          = 2'd1;
      res.r0.kind      = KIND_LED;
      res.r0.led_on    = led_level(mode_r, phase_inc);
      res.r0.last      = 1'b1;
    end else if (key_raw < NUM_KEYS) begin
      if (k == KEY_MODE) begin
        mode_nxt = mode_r + 2'd1;
        tmo_nxt  = '0;
      end else if (k == KEY_ENTER) begin
        mode_nxt          = MODE_LOWER;
        tmo_nxt           = '0;
        res.cnt           = 2'd1;
        res.r0.kind       = KIND_CHAR;
        res.r0.char_code  = CH_CR;
        res.r0.last       = 1'b1;
      end else if (is_repeat) begin
        pos_nxt           = np[2:0];
        tmo_nxt           = tmo_load;
        res.cnt           = 2'd2;
        res.r0.kind       = KIND_CHAR;
        res.r0.char_code  = CH_BS;
        res.r1.kind       = KIND_CHAR;
        res.r1.char_code  = char_at(mode_r, k, np[2:0]);
        res.r1.last       = 1'b1;
      end else begin
        pos_nxt           = 3'd0;
        prev_nxt          = k;
        tmo_nxt           = tmo_load;
        res.cnt           = 2'd1;
        res.r0.kind       = KIND_CHAR;
        res.r0.char_code  = char_at(mode_r, k, 3'd0);
        res.r0.last       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      pos_r   <= '0;
      prev_r  <= '0;
      tmo_r   <= '0;
      phase_r <= '0;
    end else if (commit) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      tmo_r   <= tmo_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/mtkd_resq.sv
`default_nettype none

module mtkd_resq
  import mtkd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire res_pair_t push_data,
  output logic           room,
  output logic           head_valid,
  input  wire logic      pop,
  output res_t           head
);

  localparam int PW = $clog2(RESQ_DEPTH);
  localparam int CW = $clog2(RESQ_DEPTH + 1);

  res_t          mem [RESQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_in;
  logic          n_out;

  assign n_in       = push ? push_data.cnt : 2'd0;
  assign n_out      = pop && head_valid;
  assign cnt_nxt    = cnt_r + CW'(n_in) - CW'(n_out);
  // room for a two-result item
  assign room       = cnt_r <= CW'(RESQ_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rp_r];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wp_r] <= push_data.r0;
    end
    if (n_in == 2'd2) begin
      mem[wp_r + PW'(1)] <= push_data.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(n_in);
      rp_r  <= rp_r + PW'(n_out);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/mtkd_checker.sv
`default_nettype none
`include "multi_tap_keypad_decoder_macros.svh"

module mtkd_checker
  import mtkd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_kind,
  input wire logic [7:0] out_char_code,
  input wire logic       out_led_on,
  input wire logic       out_last
);

  logic led_item;
  logic char_item;
  logic bs_item;

  assign led_item  = out_valid && out_kind == KIND_LED;
  assign char_item = out_valid && out_kind == KIND_CHAR;
  assign bs_item   = out_kind == KIND_CHAR && out_char_code == CH_BS;

  `MTKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `MTKD_ASSERT_NOW(a_led_form, led_item, out_last && out_char_code == 8'h00, "bad LED item")

  `MTKD_ASSERT_NOW(a_char_led_off, char_item, !out_led_on, "LED set on char item")

  `MTKD_ASSERT_NOW(a_first_is_bs, out_valid && !out_last, bs_item, "early result not a backspace")

endmodule

bind multi_tap_keypad_decoder mtkd_checker u_mtkd_checker (.*);

`default_nettype wire
